[rtl/visibility_zero_run_decoder_unit_macros.svh]
// ============================================================================
// Assertion macros for the visibility zero-run decoder
// Shared concurrent assertion forms used by the checker.
// ============================================================================
`ifndef VISIBILITY_ZERO_RUN_DECODER_UNIT_MACROS_SVH
`define VISIBILITY_ZERO_RUN_DECODER_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define VZRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold whenever the result channel shows valid.
`define VZRD_ASSERT_OUT(lbl, clk, rst_n, vld, cond, msg) \
  `VZRD_ASSERT(lbl, clk, rst_n, (vld |-> (cond)), msg)

`endif

[rtl/vzrd_pkg.sv]
// ============================================================================
// vzrd_pkg
// Types and constants shared by the zero-run decoder controller and datapath.
// ============================================================================
package vzrd_pkg;

  localparam int LEAF_W = 13;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 64;
  localparam int VB_W   = 4;

  localparam logic [BYTE_W-1:0] NOVIS_BYTE = 8'hff;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } vzrd_state_t;

  typedef struct packed {
    logic accept;
    logic step;
  } vzrd_cmd_t;

  typedef struct packed {
    logic start_run;
    logic emits;
    logic run_end;
    logic out_free;
  } vzrd_status_t;

endpackage

[rtl/vzrd_ctrl.sv]
// ============================================================================
// vzrd_ctrl
// Controller: accepts one transaction at a time and sequences the packing steps.
// ============================================================================
module vzrd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vzrd_pkg::vzrd_status_t status,
  output vzrd_pkg::vzrd_cmd_t    cmd
);
  import vzrd_pkg::*;

  vzrd_state_t state_r;
  vzrd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && status.start_run) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = !status.emits || status.out_free;
        if (cmd.step && status.run_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/vzrd_datapath.sv]
// ============================================================================
// vzrd_datapath
// Row state, byte packing lane and result register of the zero-run decoder.
// ============================================================================
module vzrd_datapath #(
  parameter int MAX_ROW_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vzrd_pkg::vzrd_cmd_t           cmd,
  output vzrd_pkg::vzrd_status_t        status,
  input  logic                          in_command,
  input  logic [vzrd_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          cfg_we,
  input  logic [vzrd_pkg::LEAF_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vzrd_pkg::WORD_W-1:0]   out_word,
  output logic [vzrd_pkg::VB_W-1:0]     out_valid_bytes,
  output logic                          out_row_done,
  output logic                          out_last
);
  import vzrd_pkg::*;

  localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CNT_W  = (POS_W > BYTE_W) ? POS_W : BYTE_W;
  localparam int WIDE_W = CNT_W + 1;
  localparam int RAW_W  = LEAF_W - 2;
  localparam logic [RAW_W-1:0] MAX_LEN = RAW_W'(MAX_ROW_BYTES);

  logic [LEAF_W-1:0] leaf_r;
  logic [WORD_W-1:0] buf_r;
  logic [VB_W-1:0]   fill_r;
  logic [POS_W-1:0]  pos_r;
  logic              await_r;
  logic [CNT_W-1:0]  rem_r;
  logic [BYTE_W-1:0] byte_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [VB_W-1:0]   out_vb_r;
  logic              out_done_r;
  logic              out_last_r;

  logic [LEAF_W:0]   len_sum;
  logic [RAW_W-1:0]  len_raw;
  logic [RAW_W-1:0]  len_clamp;
  logic [POS_W-1:0]  rlen;
  logic [VB_W-1:0]   avail;
  logic [POS_W-1:0]  left;
  logic [CNT_W-1:0]  k_wide;
  logic [VB_W-1:0]   k;
  logic [VB_W-1:0]   new_fill;
  logic [POS_W-1:0]  pos_step;
  logic [CNT_W-1:0]  rem_left;
  logic              row_end;
  logic              more;
  logic              emits;
  logic              word_last;
  logic [WORD_W-1:0] merged;

  always_comb begin
    len_sum = {1'b0, leaf_r} + (LEAF_W + 1)'(7);
    len_raw = len_sum[LEAF_W:3];
    if (len_raw == '0) begin
      len_clamp = RAW_W'(1);
    end else if (len_raw > MAX_LEN) begin
      len_clamp = MAX_LEN;
    end else begin
      len_clamp = len_raw;
    end
    rlen = len_clamp[POS_W-1:0];

    avail  = VB_W'(8) - fill_r;
    left   = rlen - pos_r;
    k_wide = CNT_W'(avail);
    if (CNT_W'(left) < k_wide) begin
      k_wide = CNT_W'(left);
    end
    if (rem_r < k_wide) begin
      k_wide = rem_r;
    end
    k = k_wide[VB_W-1:0];

    new_fill  = fill_r + k;
    pos_step  = pos_r + POS_W'(k);
    rem_left  = rem_r - CNT_W'(k);
    row_end   = (pos_step == rlen);
    more      = (rem_left >= CNT_W'(8)) ||
                ((rem_left != '0) &&
                 ((WIDE_W'(pos_step) + WIDE_W'(rem_left)) >= WIDE_W'(rlen)));
    emits     = (new_fill == VB_W'(8)) || row_end;
    word_last = row_end || !more;

    for (int i = 0; i < 8; i++) begin
      if ((VB_W'(i) >= fill_r) && (VB_W'(i) < new_fill)) begin
        merged[BYTE_W*i +: BYTE_W] = byte_r;
      end else begin
        merged[BYTE_W*i +: BYTE_W] = buf_r[BYTE_W*i +: BYTE_W];
      end
    end
  end

  assign status.start_run = in_command || (in_data_byte != '0);
  assign status.emits     = emits;
  assign status.run_end   = row_end || (rem_left == '0);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_r      <= LEAF_W'(1);
      buf_r       <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      await_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        leaf_r  <= cfg_wdata;
        buf_r   <= '0;
        fill_r  <= '0;
        pos_r   <= '0;
        await_r <= 1'b0;
      end else if (cmd.accept) begin
        if (in_command) begin
          buf_r   <= '0;
          fill_r  <= '0;
          pos_r   <= '0;
          await_r <= 1'b0;
          rem_r   <= CNT_W'(rlen);
          byte_r  <= NOVIS_BYTE;
        end else if (await_r) begin
          await_r <= 1'b0;
          rem_r   <= CNT_W'(in_data_byte);
          byte_r  <= '0;
        end else if (in_data_byte == '0) begin
          await_r <= 1'b1;
        end else begin
          rem_r  <= CNT_W'(1);
          byte_r <= in_data_byte;
        end
      end else if (cmd.step) begin
        rem_r <= rem_left;
        if (emits) begin
          buf_r  <= '0;
          fill_r <= '0;
        end else begin
          buf_r  <= merged;
          fill_r <= new_fill;
        end
        if (row_end) begin
          pos_r   <= '0;
          await_r <= 1'b0;
        end else begin
          pos_r <= pos_step;
        end
      end

      if (cmd.step && emits) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emits) begin
      out_word_r <= merged;
      out_vb_r   <= new_fill;
      out_done_r <= row_end;
      out_last_r <= word_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_row_done    = out_done_r;
  assign out_last        = out_last_r;

endmodule

[rtl/visibility_zero_run_decoder_unit.sv]
// ============================================================================
// visibility_zero_run_decoder_unit
// Expands a zero-run coded visibility row into packed 64-bit words.
// ============================================================================
// The block takes one input transaction at a time. A literal byte takes the
// accept cycle and one packing step. A zero run or a no-vis row takes the
// accept cycle plus one packing step per output word segment, since the
// single eight-byte packing lane adds at most up to the next word boundary or
// row end in each step. A zero marker or a zero-length run needs no packing
// step. Stall on the result channel holds any packing step that would emit a
// word while a finished word is still waiting. Writing cfg_wdata sets
// leaf_count and restarts the row.
module visibility_zero_run_decoder_unit #(
  parameter int MAX_ROW_BYTES = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vzrd_pkg::LEAF_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [vzrd_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vzrd_pkg::WORD_W-1:0]  out_word,
  output logic [vzrd_pkg::VB_W-1:0]    out_valid_bytes,
  output logic                         out_row_done,
  output logic                         out_last
);
  import vzrd_pkg::*;

  vzrd_cmd_t    cmd;
  vzrd_status_t status;

  vzrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vzrd_datapath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .out_valid_bytes (out_valid_bytes),
    .out_row_done    (out_row_done),
    .out_last        (out_last)
  );

endmodule

[rtl/vzrd_checker.sv]
// ============================================================================
// vzrd_checker
// Port-level checks on the result channel of the zero-run decoder.
// ============================================================================
`include "visibility_zero_run_decoder_unit_macros.svh"

module vzrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_word,
  input logic [3:0]  out_valid_bytes,
  input logic        out_row_done,
  input logic        out_last
);

  `VZRD_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_valid_bytes) && $stable(out_last)), "stalled result transaction changed")
  `VZRD_ASSERT_OUT(a_vb_range, clk, rst_n, out_valid, (out_valid_bytes >= 4'd1 && out_valid_bytes <= 4'd8), "valid byte count out of range")
  `VZRD_ASSERT_OUT(a_full_mid_row, clk, rst_n, out_valid, (out_row_done || out_valid_bytes == 4'd8), "partial word before the row end")
  `VZRD_ASSERT_OUT(a_upper_zero, clk, rst_n, out_valid, ((out_word >> {out_valid_bytes, 3'b000}) == 64'd0), "byte lanes above the count are not zero")

endmodule

bind visibility_zero_run_decoder_unit vzrd_checker u_vzrd_checker (.*);
